### src/tmbd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tmbd_pkg;

    // Fixed field widths of the item interface.
    localparam int POS_W   = 20;
    localparam int HALF_W  = 10;
    localparam int COORD_W = 6;
    localparam int CFG_W   = 7;
    localparam int CFG_IDX_W = 2;

    // Positions carry four fractional bits (1/16 pixel).
    localparam int FRAC_BITS = 4;

    // Default geometry.
    localparam int TILE_SHIFT_DEF    = 4;
    localparam int MAP_SIDE_LOG2_DEF = 6;

    // Reset value of both map size registers.
    localparam logic [CFG_W-1:0] CFG_SIZE_RESET = 7'd64;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_COLUMNS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_ROWS    = 2'd1;

    // Item commands.
    localparam logic CMD_WRITE   = 1'b0;
    localparam logic CMD_RESOLVE = 1'b1;

    // Request item.
    typedef struct packed {
        logic                     cmd;
        logic [COORD_W-1:0]       tile_column;
        logic [COORD_W-1:0]       tile_row;
        logic                     tile_is_wall;
        logic signed [POS_W-1:0]  pos_x;
        logic signed [POS_W-1:0]  pos_y;
        logic [HALF_W-1:0]        half_w;
        logic [HALF_W-1:0]        half_h;
        logic                     solid;
    } in_item_t;

    // Result item.
    typedef struct packed {
        logic signed [POS_W-1:0] new_x;
        logic signed [POS_W-1:0] new_y;
    } out_item_t;

    // Shared adder control.
    typedef enum logic {
        UNIT_ADD,
        UNIT_SUB
    } unit_op_t;

    typedef struct packed {
        unit_op_t op;
        logic     sat;
    } unit_ctl_t;

endpackage

`default_nettype wire

### src/tmbd_unit.sv
`timescale 1ns / 1ps
`default_nettype none

module tmbd_unit
    import tmbd_pkg::*;
#(
    parameter int W = 26
)
(
    input  unit_ctl_t              ctl,
    input  logic signed [W-1:0]    a,
    input  logic signed [W-1:0]    b,
    output logic signed [W-1:0]    res
);

    // Limits of the signed position range, extended to the unit width.
    localparam logic signed [W-1:0] SAT_HI = {{(W-POS_W+1){1'b0}}, {(POS_W-1){1'b1}}};
    localparam logic signed [W-1:0] SAT_LO = {{(W-POS_W+1){1'b1}}, {(POS_W-1){1'b0}}};

    logic signed [W-1:0] sum;

    // One add or subtract.
    always_comb
    begin
        if (ctl.op == UNIT_SUB)
        begin
            sum = a - b;
        end
        else
        begin
            sum = a + b;
        end
    end

    // Optional clamp to the position range.
    always_comb
    begin
        res = sum;
        if (ctl.sat)
        begin
            if (sum > SAT_HI)
            begin
                res = SAT_HI;
            end
            else if (sum < SAT_LO)
            begin
                res = SAT_LO;
            end
        end
    end

endmodule

`default_nettype wire

### src/tmbd_map.sv
`timescale 1ns / 1ps
`default_nettype none

module tmbd_map
    import tmbd_pkg::*;
#(
    parameter int MAP_SIDE_LOG2 = MAP_SIDE_LOG2_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          rd_en,
    input  logic [MAP_SIDE_LOG2-1:0]      rd_addr,
    output logic [(1<<MAP_SIDE_LOG2)-1:0] rd_data,
    input  logic                          wr_en,
    input  logic [MAP_SIDE_LOG2-1:0]      wr_addr,
    input  logic [(1<<MAP_SIDE_LOG2)-1:0] wr_data,
    output logic                          busy
);

    localparam int MAP_SIDE = 1 << MAP_SIDE_LOG2;

    // One row of wall bits per word.
    logic [MAP_SIDE-1:0]      mem [MAP_SIDE];
    logic [MAP_SIDE-1:0]      rd_data_reg;
    logic [MAP_SIDE_LOG2-1:0] clr_cnt_reg;
    logic                     clr_busy_reg;

    // Clearing pass after reset: one row per cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg  <= '0;
            clr_busy_reg <= 1'b1;
        end
        else if (clr_busy_reg)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == {MAP_SIDE_LOG2{1'b1}})
            begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    // Row memory with a registered read port.
    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
        begin
            mem[clr_cnt_reg] <= '0;
        end
        else if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
    assign busy    = clr_busy_reg;

    // No access may collide with the clearing pass.
    a_no_access_while_clearing: assert property (
        @(posedge clk) disable iff (!rst_n)
        clr_busy_reg |-> (!wr_en && !rd_en)
    ) else $error("map accessed during clearing pass");

    // The pass ends right after the last row.
    a_clear_ends: assert property (
        @(posedge clk) disable iff (!rst_n)
        (clr_busy_reg && clr_cnt_reg == {MAP_SIDE_LOG2{1'b1}}) |=> !clr_busy_reg
    ) else $error("clearing pass did not end");

    // Once done, the pass never restarts without reset.
    a_clear_once: assert property (
        @(posedge clk) disable iff (!rst_n)
        !clr_busy_reg |=> !clr_busy_reg
    ) else $error("clearing pass restarted");

endmodule

`default_nettype wire

### src/tile_map_box_depenetration_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Tile-map box depenetration. A write item sets one tile of the wall map by a
// read of its row followed by a write of that row. A resolve item of a
// non-solid box goes straight to its result. A solid box first finds its
// clamped tile span and then walks it row by row; each wall tile in the span
// gets its center distance and overlap on both axes, and one that overlaps on
// both pushes the box.
// The position arithmetic goes through one shared add/subtract unit, one
// operation per cycle, and each map row is fetched once through the single
// read port of the row memory. After reset the map is cleared one row per
// cycle; no item is taken meanwhile, but configuration writes are. A finished
// result waits in an output register, and the block takes the next item while
// it waits.
module tile_map_box_depenetration_top
    import tmbd_pkg::*;
#(
    parameter int TILE_SHIFT    = TILE_SHIFT_DEF,
    parameter int MAP_SIDE_LOG2 = MAP_SIDE_LOG2_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  in_item_t             req,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output out_item_t            rsp,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int MAP_SIDE = 1 << MAP_SIDE_LOG2;
    localparam int TU       = TILE_SHIFT + FRAC_BITS;
    localparam int CW       = MAP_SIDE_LOG2 + TU;
    localparam int W        = ((POS_W > CW) ? POS_W : CW) + 3;
    localparam logic signed [W-1:0] TH = W'(2 ** (TU - 1));

    typedef enum logic [4:0] {
        S_IDLE,
        S_WR_RD,
        S_WR_WR,
        S_XLO,
        S_XHI,
        S_YLO,
        S_YHI,
        S_CHK,
        S_ROW,
        S_TILE,
        S_DX,
        S_OX,
        S_DY,
        S_OY,
        S_CMP,
        S_PUSH,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic [CFG_W-1:0]          map_columns_reg;
    logic [CFG_W-1:0]          map_rows_reg;
    logic signed [POS_W-1:0]   run_x_reg;
    logic signed [POS_W-1:0]   run_y_reg;
    logic [HALF_W-1:0]         hw_reg;
    logic [HALF_W-1:0]         hh_reg;
    logic signed [W-1:0]       hwth_reg;
    logic signed [W-1:0]       hhth_reg;
    logic signed [W-1:0]       col_lo_reg;
    logic signed [W-1:0]       col_hi_reg;
    logic signed [W-1:0]       row_lo_reg;
    logic signed [W-1:0]       row_hi_reg;
    logic [MAP_SIDE_LOG2-1:0]  c_reg;
    logic [MAP_SIDE_LOG2-1:0]  r_reg;
    logic signed [W-1:0]       dx_reg;
    logic signed [W-1:0]       dy_reg;
    logic signed [W-1:0]       ox_reg;
    logic signed [W-1:0]       oy_reg;
    logic                      take_x_reg;
    logic [MAP_SIDE_LOG2-1:0]  wr_col_reg;
    logic [MAP_SIDE_LOG2-1:0]  wr_row_reg;
    logic                      wr_wall_reg;
    logic                      wr_ok_reg;
    logic                      rsp_valid_reg;
    out_item_t                 rsp_reg;

    logic                      accept;
    logic                      out_free;
    logic                      map_busy;
    logic                      map_rd_en;
    logic [MAP_SIDE_LOG2-1:0]  map_rd_addr;
    logic [MAP_SIDE-1:0]       map_row;
    logic                      map_wr_en;
    logic [MAP_SIDE-1:0]       map_wr_data;
    logic signed [W-1:0]       col_lim;
    logic signed [W-1:0]       row_lim;
    logic signed [W-1:0]       run_x_ext;
    logic signed [W-1:0]       run_y_ext;
    logic signed [W-1:0]       cx;
    logic signed [W-1:0]       cy;
    logic signed [W-1:0]       unit_a;
    logic signed [W-1:0]       unit_b;
    logic signed [W-1:0]       unit_res;
    logic signed [W-1:0]       unit_sh;
    unit_ctl_t                 unit_ctl;
    logic                      wall_bit;
    logic                      no_overlap;
    logic                      last_col;
    logic                      last_row;
    logic                      step_tile;
    state_t                    tile_next;

    // Handshakes.
    assign req_ready = (state_reg == S_IDLE) && !map_busy;
    assign accept    = req_valid && req_ready;
    assign out_free  = !rsp_valid_reg || rsp_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Last usable column and row index; minus one when the map is empty.
    always_comb
    begin
        if (int'(map_columns_reg) < MAP_SIDE)
        begin
            col_lim = W'(map_columns_reg) - W'(1);
        end
        else
        begin
            col_lim = W'(MAP_SIDE - 1);
        end
        if (int'(map_rows_reg) < MAP_SIDE)
        begin
            row_lim = W'(map_rows_reg) - W'(1);
        end
        else
        begin
            row_lim = W'(MAP_SIDE - 1);
        end
    end

    // Operands at the unit width; tile centers are built from the indexes.
    assign run_x_ext = {{(W-POS_W){run_x_reg[POS_W-1]}}, run_x_reg};
    assign run_y_ext = {{(W-POS_W){run_y_reg[POS_W-1]}}, run_y_reg};
    assign cx = W'({c_reg, 1'b1, {(TU-1){1'b0}}});
    assign cy = W'({r_reg, 1'b1, {(TU-1){1'b0}}});

    // Operand selection for the shared unit.
    always_comb
    begin
        unit_a       = '0;
        unit_b       = '0;
        unit_ctl.op  = UNIT_ADD;
        unit_ctl.sat = 1'b0;
        case (state_reg)
            S_XLO:
            begin
                unit_a      = run_x_ext;
                unit_b      = W'(hw_reg);
                unit_ctl.op = UNIT_SUB;
            end
            S_XHI:
            begin
                unit_a = run_x_ext;
                unit_b = W'(hw_reg);
            end
            S_YLO:
            begin
                unit_a      = run_y_ext;
                unit_b      = W'(hh_reg);
                unit_ctl.op = UNIT_SUB;
            end
            S_YHI:
            begin
                unit_a = run_y_ext;
                unit_b = W'(hh_reg);
            end
            S_DX:
            begin
                unit_a      = run_x_ext;
                unit_b      = cx;
                unit_ctl.op = UNIT_SUB;
            end
            S_OX:
            begin
                // Overlap is half extent minus the absolute center distance.
                unit_a      = hwth_reg;
                unit_b      = dx_reg;
                unit_ctl.op = dx_reg[W-1] ? UNIT_ADD : UNIT_SUB;
            end
            S_DY:
            begin
                unit_a      = run_y_ext;
                unit_b      = cy;
                unit_ctl.op = UNIT_SUB;
            end
            S_OY:
            begin
                unit_a      = hhth_reg;
                unit_b      = dy_reg;
                unit_ctl.op = dy_reg[W-1] ? UNIT_ADD : UNIT_SUB;
            end
            S_CMP:
            begin
                unit_a      = ox_reg;
                unit_b      = oy_reg;
                unit_ctl.op = UNIT_SUB;
            end
            S_PUSH:
            begin
                unit_ctl.sat = 1'b1;
                if (take_x_reg)
                begin
                    unit_a      = run_x_ext;
                    unit_b      = ox_reg;
                    unit_ctl.op = dx_reg[W-1] ? UNIT_SUB : UNIT_ADD;
                end
                else
                begin
                    unit_a      = run_y_ext;
                    unit_b      = oy_reg;
                    unit_ctl.op = dy_reg[W-1] ? UNIT_SUB : UNIT_ADD;
                end
            end
            default:
            begin
                unit_ctl.op = UNIT_ADD;
            end
        endcase
    end

    tmbd_unit #(
        .W   (W)
    ) u_unit (
        .ctl (unit_ctl),
        .a   (unit_a),
        .b   (unit_b),
        .res (unit_res)
    );

    // Arithmetic shift gives the floor of the tile index.
    assign unit_sh = unit_res >>> TU;

    // Map row access: write items do a read-modify-write of one row.
    always_comb
    begin
        map_rd_en   = (state_reg == S_WR_RD) || (state_reg == S_ROW);
        map_rd_addr = (state_reg == S_WR_RD) ? wr_row_reg : r_reg;
        map_wr_en   = (state_reg == S_WR_WR) && wr_ok_reg;
        map_wr_data = map_row;
        map_wr_data[wr_col_reg] = wr_wall_reg;
    end

    tmbd_map #(
        .MAP_SIDE_LOG2 (MAP_SIDE_LOG2)
    ) u_map (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (map_rd_en),
        .rd_addr (map_rd_addr),
        .rd_data (map_row),
        .wr_en   (map_wr_en),
        .wr_addr (wr_row_reg),
        .wr_data (map_wr_data),
        .busy    (map_busy)
    );

    // Tile walk bookkeeping.
    assign wall_bit   = map_row[c_reg];
    assign no_overlap = (ox_reg <= 0) || (oy_reg <= 0);
    assign last_col   = (c_reg == col_hi_reg[MAP_SIDE_LOG2-1:0]);
    assign last_row   = (r_reg == row_hi_reg[MAP_SIDE_LOG2-1:0]);
    assign tile_next  = last_col ? (last_row ? S_DONE : S_ROW) : S_TILE;
    assign step_tile  = ((state_reg == S_TILE) && !wall_bit) ||
                        ((state_reg == S_CMP) && no_overlap) ||
                        (state_reg == S_PUSH);

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (req.cmd == CMD_WRITE)
                    begin
                        state_next = S_WR_RD;
                    end
                    else if (req.solid)
                    begin
                        state_next = S_XLO;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_WR_RD: state_next = S_WR_WR;
            S_WR_WR: state_next = S_IDLE;
            S_XLO:   state_next = S_XHI;
            S_XHI:   state_next = S_YLO;
            S_YLO:   state_next = S_YHI;
            S_YHI:   state_next = S_CHK;
            S_CHK:
            begin
                if ((col_lo_reg > col_hi_reg) || (row_lo_reg > row_hi_reg))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_ROW;
                end
            end
            S_ROW:   state_next = S_TILE;
            S_TILE:  state_next = wall_bit ? S_DX : tile_next;
            S_DX:    state_next = S_OX;
            S_OX:    state_next = S_DY;
            S_DY:    state_next = S_OY;
            S_OY:    state_next = S_CMP;
            S_CMP:   state_next = no_overlap ? tile_next : S_PUSH;
            S_PUSH:  state_next = tile_next;
            S_DONE:  state_next = out_free ? S_IDLE : S_DONE;
            default: state_next = S_IDLE;
        endcase
    end

    // State, configuration, datapath and output registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            map_columns_reg <= CFG_SIZE_RESET;
            map_rows_reg    <= CFG_SIZE_RESET;
            run_x_reg       <= '0;
            run_y_reg       <= '0;
            hw_reg          <= '0;
            hh_reg          <= '0;
            hwth_reg        <= '0;
            hhth_reg        <= '0;
            col_lo_reg      <= '0;
            col_hi_reg      <= '0;
            row_lo_reg      <= '0;
            row_hi_reg      <= '0;
            c_reg           <= '0;
            r_reg           <= '0;
            dx_reg          <= '0;
            dy_reg          <= '0;
            ox_reg          <= '0;
            oy_reg          <= '0;
            take_x_reg      <= 1'b0;
            wr_col_reg      <= '0;
            wr_row_reg      <= '0;
            wr_wall_reg     <= 1'b0;
            wr_ok_reg       <= 1'b0;
            rsp_valid_reg   <= 1'b0;
            rsp_reg         <= '0;
        end
        else
        begin
            state_reg <= state_next;

            // Configuration writes.
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_MAP_COLUMNS: map_columns_reg <= cfg_data;
                    CFG_MAP_ROWS:    map_rows_reg    <= cfg_data;
                    default:         ;
                endcase
            end

            // Output register.
            if ((state_reg == S_DONE) && out_free)
            begin
                rsp_valid_reg <= 1'b1;
                rsp_reg.new_x <= run_x_reg;
                rsp_reg.new_y <= run_y_reg;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end

            // Datapath.
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        wr_col_reg  <= MAP_SIDE_LOG2'(req.tile_column);
                        wr_row_reg  <= MAP_SIDE_LOG2'(req.tile_row);
                        wr_wall_reg <= req.tile_is_wall;
                        wr_ok_reg   <= (int'(req.tile_column) < MAP_SIDE) &&
                                       (int'(req.tile_row) < MAP_SIDE);
                        if (req.cmd == CMD_RESOLVE)
                        begin
                            run_x_reg <= req.pos_x;
                            run_y_reg <= req.pos_y;
                            hw_reg    <= req.half_w;
                            hh_reg    <= req.half_h;
                            hwth_reg  <= W'(req.half_w) + TH;
                            hhth_reg  <= W'(req.half_h) + TH;
                        end
                    end
                end
                S_XLO: col_lo_reg <= (unit_sh < 0) ? '0 : unit_sh;
                S_XHI: col_hi_reg <= (unit_sh > col_lim) ? col_lim : unit_sh;
                S_YLO: row_lo_reg <= (unit_sh < 0) ? '0 : unit_sh;
                S_YHI: row_hi_reg <= (unit_sh > row_lim) ? row_lim : unit_sh;
                S_CHK:
                begin
                    c_reg <= col_lo_reg[MAP_SIDE_LOG2-1:0];
                    r_reg <= row_lo_reg[MAP_SIDE_LOG2-1:0];
                end
                S_DX:  dx_reg <= unit_res;
                S_OX:  ox_reg <= unit_res;
                S_DY:  dy_reg <= unit_res;
                S_OY:  oy_reg <= unit_res;
                S_CMP: take_x_reg <= unit_res[W-1];
                S_PUSH:
                begin
                    if (take_x_reg)
                    begin
                        run_x_reg <= unit_res[POS_W-1:0];
                    end
                    else
                    begin
                        run_y_reg <= unit_res[POS_W-1:0];
                    end
                end
                default: ;
            endcase

            // Move to the next tile of the span, row by row.
            if (step_tile)
            begin
                if (last_col)
                begin
                    c_reg <= col_lo_reg[MAP_SIDE_LOG2-1:0];
                    r_reg <= r_reg + 1'b1;
                end
                else
                begin
                    c_reg <= c_reg + 1'b1;
                end
            end
        end
    end

    // The walk never leaves the clamped span.
    a_tile_in_span: assert property (
        @(posedge clk) disable iff (!rst_n)
        (state_reg == S_TILE) |->
            ((W'(c_reg) >= col_lo_reg) && (W'(c_reg) <= col_hi_reg) &&
             (W'(r_reg) >= row_lo_reg) && (W'(r_reg) <= row_hi_reg))
    ) else $error("tile walk outside span");

    // A push happens only for a strict overlap on both axes.
    a_push_needs_overlap: assert property (
        @(posedge clk) disable iff (!rst_n)
        (state_reg == S_PUSH) |-> ((ox_reg > 0) && (oy_reg > 0))
    ) else $error("push without overlap");

    // A result is produced only by the end of a resolve item.
    a_result_from_done: assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == S_DONE)
    ) else $error("result without a finished resolve item");

    // No item is taken while the map is being cleared.
    a_no_accept_while_clearing: assert property (
        @(posedge clk) disable iff (!rst_n)
        map_busy |-> !req_ready
    ) else $error("item accepted during clearing pass");

endmodule

`default_nettype wire

### test/tile_map_box_depenetration_top_test.sv
`timescale 1ns / 1ps

module tile_map_box_depenetration_top_test;
    import tmbd_pkg::*;

    // Geometry at the default parameters of the block.
    localparam int MAP_SIDE   = 1 << MAP_SIDE_LOG2_DEF;
    localparam int TILE_LOG2  = TILE_SHIFT_DEF + FRAC_BITS;
    localparam int TILE_UNITS = 1 << TILE_LOG2;
    localparam int HALF_TILE  = TILE_UNITS / 2;
    localparam int MAP_UNITS  = MAP_SIDE * TILE_UNITS;
    localparam longint POS_HI = 524287;
    localparam longint POS_LO = -524288;

    // Indexes that hold no register; writes there must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

    // Center of tile 5 on either axis, used by the directed boxes.
    localparam int CTR5 = 5 * TILE_UNITS + HALF_TILE;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 req_valid = 1'b0;
    logic                 req_ready;
    in_item_t             req = '0;
    logic                 rsp_valid;
    logic                 rsp_ready = 1'b0;
    out_item_t            rsp;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_MAP_COLUMNS;
    logic [CFG_W-1:0]     cfg_data = CFG_SIZE_RESET;

    // Wall map copy, map size registers and the queue of corrected positions.
    class box_resolve_scoreboard;
        bit        wall_bits [MAP_SIDE * MAP_SIDE];
        int        col_limit;
        int        row_limit;
        out_item_t expected_pos [$];
        int        errors;

        function new();
            foreach (wall_bits[i])
                wall_bits[i] = 1'b0;
            col_limit = CFG_SIZE_RESET;
            row_limit = CFG_SIZE_RESET;
            errors = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            if (idx == CFG_MAP_COLUMNS)
                col_limit = data;
            else if (idx == CFG_MAP_ROWS)
                row_limit = data;
        endfunction

        function longint clamp_pos(longint v);
            if (v > POS_HI)
                return POS_HI;
            if (v < POS_LO)
                return POS_LO;
            return v;
        endfunction

        // Applies one accepted item and queues the position it should return.
        function void note_item(in_item_t it);
            longint    rx, ry, hw, hh, c_lo, c_hi, r_lo, r_hi, cols, rows;
            longint    r, c, dx, dy, ox, oy;
            out_item_t res;
            if (it.cmd == CMD_WRITE)
            begin
                wall_bits[it.tile_row * MAP_SIDE + it.tile_column] = it.tile_is_wall;
                return;
            end
            rx = $signed(it.pos_x);
            ry = $signed(it.pos_y);
            hw = it.half_w;
            hh = it.half_h;
            if (it.solid)
            begin
                // The span is fixed from the input position; pushes do not move it.
                c_lo = (rx - hw) >>> TILE_LOG2;
                c_hi = (rx + hw) >>> TILE_LOG2;
                r_lo = (ry - hh) >>> TILE_LOG2;
                r_hi = (ry + hh) >>> TILE_LOG2;
                cols = (col_limit < MAP_SIDE) ? col_limit : MAP_SIDE;
                rows = (row_limit < MAP_SIDE) ? row_limit : MAP_SIDE;
                if (c_lo < 0)
                    c_lo = 0;
                if (r_lo < 0)
                    r_lo = 0;
                if (c_hi > cols - 1)
                    c_hi = cols - 1;
                if (r_hi > rows - 1)
                    r_hi = rows - 1;
                for (r = r_lo; r <= r_hi; r++)
                begin
                    for (c = c_lo; c <= c_hi; c++)
                    begin
                        if (!wall_bits[r * MAP_SIDE + c])
                            continue;
                        dx = rx - (c * TILE_UNITS + HALF_TILE);
                        dy = ry - (r * TILE_UNITS + HALF_TILE);
                        ox = hw + HALF_TILE - ((dx < 0) ? -dx : dx);
                        oy = hh + HALF_TILE - ((dy < 0) ? -dy : dy);
                        if (ox <= 0 || oy <= 0)
                            continue;
                        // Smaller overlap wins; a tie pushes along y.
                        if (ox < oy)
                            rx = clamp_pos(rx + ((dx >= 0) ? ox : -ox));
                        else
                            ry = clamp_pos(ry + ((dy >= 0) ? oy : -oy));
                    end
                end
            end
            res.new_x = rx[POS_W-1:0];
            res.new_y = ry[POS_W-1:0];
            expected_pos = {expected_pos, res};
        endfunction

        // Compares one returned position with the oldest expectation.
        function void check_pos(out_item_t got);
            out_item_t exp_pos;
            if (expected_pos.size() == 0)
            begin
                $display("%0t: result with nothing expected: x %0d y %0d", $time,
                         $signed(got.new_x), $signed(got.new_y));
                errors++;
                return;
            end
            exp_pos = expected_pos.pop_front();
            if (got.new_x !== exp_pos.new_x)
            begin
                $display("%0t: new_x expected %0d got %0d", $time,
                         $signed(exp_pos.new_x), $signed(got.new_x));
                errors++;
            end
            if (got.new_y !== exp_pos.new_y)
            begin
                $display("%0t: new_y expected %0d got %0d", $time,
                         $signed(exp_pos.new_y), $signed(got.new_y));
                errors++;
            end
        endfunction
    endclass

    box_resolve_scoreboard sb;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_asks = 0;
    int hold_taken = 0;
    int hold_left = 0;

    tile_map_box_depenetration_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Hard limit on the run.
    initial
    begin
        #200_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // Result side: check each accepted item and choose the next ready value.
    always @(posedge clk)
    begin
        if (rsp_valid && rsp_ready)
            sb.check_pos(rsp);
        if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            rsp_ready <= 1'b0;
        end
        else if (hold_asks != hold_taken)
        begin
            hold_taken <= hold_taken + 1;
            hold_left <= 400;
            rsp_ready <= 1'b0;
        end
        else
        begin
            rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic in_item_t raw_bits();
        logic [95:0] raw;
        raw = {$urandom, $urandom, $urandom};
        return raw[$bits(in_item_t)-1:0];
    endfunction

    // Tile write; the resolve fields carry random junk.
    function automatic in_item_t tile_write(int col, int row, bit wall);
        in_item_t it;
        it = raw_bits();
        it.cmd = CMD_WRITE;
        it.tile_column = col[COORD_W-1:0];
        it.tile_row = row[COORD_W-1:0];
        it.tile_is_wall = wall;
        return it;
    endfunction

    // Box resolve; the write fields carry random junk.
    function automatic in_item_t box(int x, int y, int hw, int hh, bit solid);
        in_item_t it;
        it = raw_bits();
        it.cmd = CMD_RESOLVE;
        it.pos_x = x[POS_W-1:0];
        it.pos_y = y[POS_W-1:0];
        it.half_w = hw[HALF_W-1:0];
        it.half_h = hh[HALF_W-1:0];
        it.solid = solid;
        return it;
    endfunction

    // Mostly walls near the origin and boxes over the map, with some noise.
    function automatic in_item_t random_item();
        int pick, span, x, y, hw, hh;
        pick = $urandom_range(99);
        if (pick < 35)
        begin
            if ($urandom_range(3) == 0)
                return tile_write($urandom_range(63), $urandom_range(63),
                                  $urandom_range(9) < 7);
            return tile_write($urandom_range(15), $urandom_range(15),
                              $urandom_range(9) < 7);
        end
        if (pick < 90)
        begin
            span = ($urandom_range(2) == 0) ? MAP_UNITS + 512 : 16 * TILE_UNITS + 512;
            x = int'($urandom_range(span)) - 256;
            y = int'($urandom_range(span)) - 256;
            hw = ($urandom_range(9) == 0) ? $urandom_range(1023) : $urandom_range(512);
            hh = ($urandom_range(9) == 0) ? $urandom_range(1023) : $urandom_range(512);
            return box(x, y, hw, hh, $urandom_range(19) != 0);
        end
        return raw_bits();
    endfunction

    // Offer one item, after a random gap, and hold it until accepted.
    task automatic send_item(input in_item_t it);
        int gap;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= it;
        do
            @(posedge clk);
        while (req_ready !== 1'b1);
        sb.note_item(it);
    endtask

    // Stop offering, wait for every expected result, then let the block settle.
    task automatic wait_idle(input int settle);
        int spin;
        spin = 0;
        req_valid <= 1'b0;
        while (sb.expected_pos.size() != 0 && spin < 200000)
        begin
            @(posedge clk);
            spin++;
        end
        if (sb.expected_pos.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, sb.expected_pos.size());
            sb.errors++;
            sb.expected_pos.delete();
        end
        repeat (settle) @(posedge clk);
    endtask

    // Write both map sizes, then junk to the unused indexes.
    task automatic write_regs(input logic [CFG_W-1:0] cols, input logic [CFG_W-1:0] rows);
        cfg_we <= 1'b1;
        cfg_index <= CFG_MAP_COLUMNS;
        cfg_data <= cols;
        @(posedge clk);
        sb.write_reg(CFG_MAP_COLUMNS, cols);
        cfg_index <= CFG_MAP_ROWS;
        cfg_data <= rows;
        @(posedge clk);
        sb.write_reg(CFG_MAP_ROWS, rows);
        cfg_index <= CFG_SPARE_LO;
        cfg_data <= 7'($urandom_range(127));
        @(posedge clk);
        cfg_index <= CFG_SPARE_HI;
        cfg_data <= 7'($urandom_range(127));
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        int phase_cols [8];
        int phase_rows [8];
        int cols, rows;
        phase_cols = '{64, 16, 1, 127, 64, 40, -1, 64};
        phase_rows = '{64, 16, 1, 127, 0, 12, -1, 64};
        sb = new();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        write_regs(7'd64, 7'd64);

        // Walls around tile (5,5), at the map corners, and one set then cleared.
        send_item(tile_write(5, 5, 1'b1));
        send_item(tile_write(6, 5, 1'b1));
        send_item(tile_write(0, 0, 1'b1));
        send_item(tile_write(63, 63, 1'b1));
        send_item(tile_write(63, 0, 1'b1));
        send_item(tile_write(7, 7, 1'b1));
        send_item(tile_write(7, 7, 1'b0));

        // Centered box is a tie and goes along y; then x, y and a grazing contact.
        send_item(box(CTR5, CTR5, 64, 64, 1'b1));
        send_item(box(CTR5 - 180, CTR5, 64, 64, 1'b1));
        send_item(box(CTR5 + 40, CTR5 + 150, 64, 64, 1'b1));
        send_item(box(CTR5, CTR5, 0, 0, 1'b1));
        send_item(box(CTR5 + HALF_TILE, CTR5, 128, 16, 1'b1));
        send_item(box(CTR5 - 192, CTR5, 64, 64, 1'b1));
        send_item(box(-10, 100, 40, 40, 1'b1));
        send_item(box(MAP_UNITS - 1, MAP_UNITS - 1, 100, 100, 1'b1));
        send_item(box(MAP_UNITS - 4, 0, 50, 50, 1'b1));
        send_item(box(-524288, -524288, 1023, 1023, 1'b1));
        send_item(box(524287, 524287, 1023, 1023, 1'b1));
        send_item(box(524287, -524288, 1023, 0, 1'b0));
        send_item(box(CTR5, CTR5, 1023, 1023, 1'b1));
        send_item(box(CTR5, CTR5, 64, 64, 1'b0));

        // Zero columns opens every tile; oversize acts as full; a small map cuts.
        wait_idle(16);
        write_regs(7'd0, 7'd64);
        send_item(box(CTR5, CTR5, 64, 64, 1'b1));
        wait_idle(16);
        write_regs(7'd127, 7'd127);
        send_item(box(MAP_UNITS - 1, MAP_UNITS - 1, 100, 100, 1'b1));
        wait_idle(16);
        write_regs(7'd6, 7'd6);
        send_item(box(CTR5 + HALF_TILE, CTR5, 128, 16, 1'b1));

        // Random phases over the idling modes and several map sizes.
        for (int ph = 0; ph < 8; ph++)
        begin
            wait_idle(16);
            cols = (phase_cols[ph] < 0) ? $urandom_range(127) : phase_cols[ph];
            rows = (phase_rows[ph] < 0) ? $urandom_range(127) : phase_rows[ph];
            write_regs(cols[CFG_W-1:0], rows[CFG_W-1:0]);
            case (ph % 4)
                0:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 66;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 66;
                end
                default:
                begin
                    send_idle_pct = 34;
                    recv_stall_pct = 34;
                end
            endcase
            // A long receiver hold-off while items keep coming fills the block.
            if (ph == 1 || ph == 4)
                hold_asks++;
            repeat (140) send_item(random_item());
        end

        wait_idle(700);
        if (sb.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
